// ----- rtl/dcmp_pkg.sv -----
`timescale 1ns / 1ps

package dcmp_pkg;

    // APB address width: six 32-bit registers at byte addresses 0 to 20
    localparam int unsigned APB_AW = 5;

    // Register reset values
    localparam logic [30:0]        TORQUE_LIMIT_RST  = 31'h7FFF_FFFF;
    localparam logic [30:0]        INERTIA_RECIP_RST = 31'd65536;
    localparam logic signed [31:0] POSITION_MIN_RST  = 32'sh8000_0000;
    localparam logic signed [31:0] POSITION_MAX_RST  = 32'sh7FFF_FFFF;

    // Friction gain and the divide-by-1000 reciprocal: floor(x / 1000) equals
    // (x * RECIP_1000) >> BAND_SHIFT for every 31-bit x
    localparam logic signed [32:0] FRICTION_GAIN = 33'sd1000;
    localparam logic signed [32:0] RECIP_1000    = 33'sd2199023256;
    localparam int unsigned        BAND_SHIFT    = 41;
    localparam int unsigned        BAND_W        = 22;

    typedef struct packed {
        logic [30:0]        torque_limit;
        logic [30:0]        friction_torque;
        logic [30:0]        damping;
        logic [30:0]        inertia_recip;
        logic signed [31:0] position_min;
        logic signed [31:0] position_max;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BAND,
        ST_ANCHOR,
        ST_FRIC,
        ST_EFF,
        ST_ACC,
        ST_ACC_SAT,
        ST_MUL_DT,
        ST_VEL,
        ST_MUL_POS,
        ST_POS
    } t_state;

    typedef enum logic [2:0] {
        MUL_BAND,
        MUL_DAMP,
        MUL_FRIC,
        MUL_INERTIA,
        MUL_ACC_DT,
        MUL_VEL_DT
    } t_mul_sel;

    typedef struct packed {
        t_mul_sel mul_sel;
        logic     ld_item;
        logic     ld_anchor;
        logic     ld_part;
        logic     ld_eff;
        logic     ld_acc;
        logic     ld_vel;
        logic     commit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_busy;
    } t_dp_sts;

endpackage

// ----- rtl/dcmp_in_if.sv -----
`timescale 1ns / 1ps

interface dcmp_in_if;
    logic               valid;
    logic               ready;
    logic [31:0]        dt;
    logic signed [31:0] motor_torque;
    logic signed [31:0] load_torque;

    modport source (output valid, dt, motor_torque, load_torque, input ready);
    modport sink (input valid, dt, motor_torque, load_torque, output ready);
endinterface

// ----- rtl/dcmp_out_if.sv -----
`timescale 1ns / 1ps

interface dcmp_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] position;
    logic signed [31:0] velocity;
    logic signed [31:0] effort_out;
    logic               effort_valid;
    logic signed [31:0] applied_torque;

    modport source (output valid, position, velocity, effort_out, effort_valid,
                    applied_torque, input ready);
    modport sink (input valid, position, velocity, effort_out, effort_valid,
                  applied_torque, output ready);
endinterface

// ----- rtl/dcmp_ctrl.sv -----
`timescale 1ns / 1ps

module dcmp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  dcmp_pkg::t_dp_sts i_sts,
    output logic              o_in_ready,
    output dcmp_pkg::t_dp_cmd o_cmd
);

    dcmp_pkg::t_state r_state;
    dcmp_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcmp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Step through the sequence, hold in the last step while the full result slot is not read
    always_comb begin
        n_state = r_state;
        case (r_state)
            dcmp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = dcmp_pkg::ST_BAND;
                end
            end
            dcmp_pkg::ST_BAND:    n_state = dcmp_pkg::ST_ANCHOR;
            dcmp_pkg::ST_ANCHOR:  n_state = dcmp_pkg::ST_FRIC;
            dcmp_pkg::ST_FRIC:    n_state = dcmp_pkg::ST_EFF;
            dcmp_pkg::ST_EFF:     n_state = dcmp_pkg::ST_ACC;
            dcmp_pkg::ST_ACC:     n_state = dcmp_pkg::ST_ACC_SAT;
            dcmp_pkg::ST_ACC_SAT: n_state = dcmp_pkg::ST_MUL_DT;
            dcmp_pkg::ST_MUL_DT:  n_state = dcmp_pkg::ST_VEL;
            dcmp_pkg::ST_VEL:     n_state = dcmp_pkg::ST_MUL_POS;
            dcmp_pkg::ST_MUL_POS: n_state = dcmp_pkg::ST_POS;
            dcmp_pkg::ST_POS: begin
                if (!i_sts.out_busy) begin
                    n_state = dcmp_pkg::ST_IDLE;
                end
            end
            default: n_state = dcmp_pkg::ST_IDLE;
        endcase
    end

    // Drive datapath commands for each step
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd           = '0;
        o_cmd.mul_sel   = dcmp_pkg::MUL_BAND;
        case (r_state)
            dcmp_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.ld_item = i_in_valid;
            end
            dcmp_pkg::ST_BAND: begin
                o_cmd.mul_sel = dcmp_pkg::MUL_BAND;
            end
            dcmp_pkg::ST_ANCHOR: begin
                o_cmd.ld_anchor = 1'b1;
                o_cmd.mul_sel   = dcmp_pkg::MUL_DAMP;
            end
            dcmp_pkg::ST_FRIC: begin
                o_cmd.ld_part = 1'b1;
                o_cmd.mul_sel = dcmp_pkg::MUL_FRIC;
            end
            dcmp_pkg::ST_EFF: begin
                o_cmd.ld_eff = 1'b1;
            end
            dcmp_pkg::ST_ACC: begin
                o_cmd.mul_sel = dcmp_pkg::MUL_INERTIA;
            end
            dcmp_pkg::ST_ACC_SAT: begin
                o_cmd.ld_acc = 1'b1;
            end
            dcmp_pkg::ST_MUL_DT: begin
                o_cmd.mul_sel = dcmp_pkg::MUL_ACC_DT;
            end
            dcmp_pkg::ST_VEL: begin
                o_cmd.ld_vel = 1'b1;
            end
            dcmp_pkg::ST_MUL_POS: begin
                o_cmd.mul_sel = dcmp_pkg::MUL_VEL_DT;
            end
            dcmp_pkg::ST_POS: begin
                // keep the position product steady while stalled
                o_cmd.mul_sel = dcmp_pkg::MUL_VEL_DT;
                o_cmd.commit  = !i_sts.out_busy;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/dcmp_dp.sv -----
`timescale 1ns / 1ps

module dcmp_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dcmp_pkg::t_cfg     i_cfg,
    input  dcmp_pkg::t_dp_cmd  i_cmd,
    output dcmp_pkg::t_dp_sts  o_sts,
    input  logic [31:0]        i_dt,
    input  logic signed [31:0] i_motor_torque,
    input  logic signed [31:0] i_load_torque,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_position,
    output logic signed [31:0] o_velocity,
    output logic signed [31:0] o_effort_out,
    output logic               o_effort_valid,
    output logic signed [31:0] o_applied_torque
);

    localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
    localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] y;
        if (x > SAT_MAX) begin
            y = 32'sh7FFF_FFFF;
        end else if (x < SAT_MIN) begin
            y = 32'sh8000_0000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    // Item and step registers
    logic [31:0]        r_dt;
    logic signed [31:0] r_cmd;
    logic signed [31:0] r_load;
    logic signed [65:0] r_prod;
    logic signed [33:0] r_part;
    logic signed [31:0] r_eff;
    logic signed [31:0] r_acc;
    logic signed [31:0] r_vnew;

    // Plant state
    logic signed [31:0] r_pos;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_anchor;

    // Result slot
    logic               r_out_valid;
    logic signed [31:0] r_out_position;
    logic signed [31:0] r_out_velocity;
    logic signed [31:0] r_out_effort;
    logic               r_out_effort_valid;
    logic signed [31:0] r_out_applied;

    logic signed [32:0] lim_pos;
    logic signed [32:0] lim_neg;
    logic signed [32:0] cmd_ext;
    logic signed [31:0] cmd_clamped;
    logic signed [33:0] band;
    logic signed [33:0] diff;
    logic signed [31:0] anchor_next;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_prod;
    logic signed [31:0] damp;
    logic signed [33:0] part_next;
    logic signed [31:0] fric;
    logic signed [31:0] npos;
    logic signed [31:0] fin_pos;
    logic               stop_hit;

    // Clamp the command to the symmetric torque limit
    always_comb begin
        lim_pos = $signed({2'b00, i_cfg.torque_limit});
        lim_neg = -lim_pos;
        cmd_ext = 33'(i_motor_torque);
        if (cmd_ext > lim_pos) begin
            cmd_clamped = lim_pos[31:0];
        end else if (cmd_ext < lim_neg) begin
            cmd_clamped = lim_neg[31:0];
        end else begin
            cmd_clamped = i_motor_torque;
        end
    end

    // Drag the friction anchor to within the band around the position
    always_comb begin
        band = $signed({12'd0, r_prod[dcmp_pkg::BAND_SHIFT +: dcmp_pkg::BAND_W]});
        diff = 34'(r_pos) - 34'(r_anchor);
        if (diff < -band) begin
            anchor_next = sat32(66'(34'(r_pos) + band));
        end else if (diff > band) begin
            anchor_next = sat32(66'(34'(r_pos) - band));
        end else begin
            anchor_next = r_anchor;
        end
    end

    // Select operands of the shared multiplier
    always_comb begin
        case (i_cmd.mul_sel)
            dcmp_pkg::MUL_BAND: begin
                mul_a = $signed({2'b00, i_cfg.friction_torque});
                mul_b = dcmp_pkg::RECIP_1000;
            end
            dcmp_pkg::MUL_DAMP: begin
                mul_a = $signed({2'b00, i_cfg.damping});
                mul_b = 33'(r_vel);
            end
            dcmp_pkg::MUL_FRIC: begin
                mul_a = 33'(r_pos) - 33'(r_anchor);
                mul_b = dcmp_pkg::FRICTION_GAIN;
            end
            dcmp_pkg::MUL_INERTIA: begin
                mul_a = 33'(r_eff);
                mul_b = $signed({2'b00, i_cfg.inertia_recip});
            end
            dcmp_pkg::MUL_ACC_DT: begin
                mul_a = 33'(r_acc);
                mul_b = $signed({1'b0, r_dt});
            end
            dcmp_pkg::MUL_VEL_DT: begin
                mul_a = 33'(r_vnew);
                mul_b = $signed({1'b0, r_dt});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_prod = mul_a * mul_b;
    end

    // Partial effort, friction and the final position with its stops
    always_comb begin
        damp      = sat32(r_prod >>> 16);
        part_next = 34'(r_cmd) + 34'(r_load) - 34'(damp);
        fric      = sat32(r_prod);
        npos      = sat32(66'(r_pos) + (r_prod >>> 32));
        stop_hit  = 1'b1;
        if (npos < i_cfg.position_min) begin
            fin_pos = i_cfg.position_min;
        end else if (npos > i_cfg.position_max) begin
            fin_pos = i_cfg.position_max;
        end else begin
            fin_pos  = npos;
            stop_hit = 1'b0;
        end
    end

    // Step registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_prod;
        if (i_cmd.ld_item) begin
            r_dt   <= i_dt;
            r_cmd  <= cmd_clamped;
            r_load <= i_load_torque;
        end
        if (i_cmd.ld_part) begin
            r_part <= part_next;
        end
        if (i_cmd.ld_eff) begin
            r_eff <= sat32(66'(r_part) + 66'(fric));
        end
        if (i_cmd.ld_acc) begin
            r_acc <= sat32(r_prod >>> 16);
        end
        if (i_cmd.ld_vel) begin
            r_vnew <= sat32(66'(r_vel) + (r_prod >>> 32));
        end
        if (i_cmd.commit) begin
            r_out_position     <= fin_pos;
            r_out_velocity     <= stop_hit ? 32'sd0 : r_vnew;
            r_out_effort       <= stop_hit ? 32'sd0 : r_eff;
            r_out_effort_valid <= !stop_hit;
            r_out_applied      <= r_cmd;
        end
    end

    // Plant state and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_vel       <= '0;
            r_anchor    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ld_anchor) begin
                r_anchor <= anchor_next;
            end
            if (i_cmd.commit) begin
                r_pos       <= fin_pos;
                r_vel       <= stop_hit ? 32'sd0 : r_vnew;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_busy   = r_out_valid && !i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_position       = r_out_position;
    assign o_velocity       = r_out_velocity;
    assign o_effort_out     = r_out_effort;
    assign o_effort_valid   = r_out_effort_valid;
    assign o_applied_torque = r_out_applied;

endmodule

// ----- rtl/dc_motor_plant_step.sv -----
`timescale 1ns / 1ps

// One semi-implicit Euler step of a DC motor with stiction per input item, in
// Q16.16 fixed point (dt in Q0.32), saturating at 32 bits. The block takes one
// item at a time: an item is accepted only while the sequencer is idle, and its
// result is loaded into the output register at the end of the final step, after
// which the sequencer is idle again. A single shared 33x33 multiplier forms the
// friction band, damping, friction, acceleration and both dt products in turn,
// each registered before use. A finished result may wait in the output register
// while the next item is already being worked on; the sequencer holds its final
// step only if that register is still occupied and not being read.
// Registers sit at byte addresses 0 (torque_limit), 4 (friction_torque),
// 8 (damping), 12 (inertia_recip), 16 (position_min) and 20 (position_max);
// write them only while no item is in flight.

module dc_motor_plant_step (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dcmp_in_if.sink                       i_item,
    dcmp_out_if.source                    o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dcmp_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        REG_TORQUE_LIMIT,
        REG_FRICTION_TORQUE,
        REG_DAMPING,
        REG_INERTIA_RECIP,
        REG_POSITION_MIN,
        REG_POSITION_MAX
    } t_reg_idx;

    dcmp_pkg::t_cfg    r_cfg;
    dcmp_pkg::t_dp_cmd cmd;
    dcmp_pkg::t_dp_sts sts;
    t_reg_idx          reg_idx;
    logic              cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[dcmp_pkg::APB_AW-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.torque_limit    <= dcmp_pkg::TORQUE_LIMIT_RST;
            r_cfg.friction_torque <= '0;
            r_cfg.damping         <= '0;
            r_cfg.inertia_recip   <= dcmp_pkg::INERTIA_RECIP_RST;
            r_cfg.position_min    <= dcmp_pkg::POSITION_MIN_RST;
            r_cfg.position_max    <= dcmp_pkg::POSITION_MAX_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_TORQUE_LIMIT:    r_cfg.torque_limit    <= pwdata[30:0];
                REG_FRICTION_TORQUE: r_cfg.friction_torque <= pwdata[30:0];
                REG_DAMPING:         r_cfg.damping         <= pwdata[30:0];
                REG_INERTIA_RECIP:   r_cfg.inertia_recip   <= pwdata[30:0];
                REG_POSITION_MIN:    r_cfg.position_min    <= pwdata;
                REG_POSITION_MAX:    r_cfg.position_max    <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // Read back configuration registers
    always_comb begin
        case (reg_idx)
            REG_TORQUE_LIMIT:    prdata = {1'b0, r_cfg.torque_limit};
            REG_FRICTION_TORQUE: prdata = {1'b0, r_cfg.friction_torque};
            REG_DAMPING:         prdata = {1'b0, r_cfg.damping};
            REG_INERTIA_RECIP:   prdata = {1'b0, r_cfg.inertia_recip};
            REG_POSITION_MIN:    prdata = r_cfg.position_min;
            REG_POSITION_MAX:    prdata = r_cfg.position_max;
            default:             prdata = '0;
        endcase
    end

    dcmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_sts      (sts),
        .o_in_ready (i_item.ready),
        .o_cmd      (cmd)
    );

    dcmp_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_dt             (i_item.dt),
        .i_motor_torque   (i_item.motor_torque),
        .i_load_torque    (i_item.load_torque),
        .i_out_ready      (o_result.ready),
        .o_out_valid      (o_result.valid),
        .o_position       (o_result.position),
        .o_velocity       (o_result.velocity),
        .o_effort_out     (o_result.effort_out),
        .o_effort_valid   (o_result.effort_valid),
        .o_applied_torque (o_result.applied_torque)
    );

endmodule

// ----- dv/dcmp_reg_map_pkg.sv -----
`timescale 1ns / 1ps

package dcmp_reg_map_pkg;

    // Register indexes; the byte address of each is 4 times its index
    typedef enum logic [2:0] {
        REG_TORQUE_LIMIT,
        REG_FRICTION_TORQUE,
        REG_DAMPING,
        REG_INERTIA_RECIP,
        REG_POSITION_MIN,
        REG_POSITION_MAX
    } t_reg_idx;

endpackage

// ----- dv/dcmp_motion_checker.sv -----
`timescale 1ns / 1ps

module dcmp_motion_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dcmp_in_if                          item_ch,
    dcmp_out_if                         result_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [dcmp_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import dcmp_pkg::*;
    import dcmp_reg_map_pkg::*;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam longint STICTION_GAIN = 64'sd1000;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] effort_out;
        logic               effort_valid;
        logic signed [31:0] applied_torque;
    } t_motion;

    // Configuration copy, taken from the register bus
    t_cfg   plant_cfg;
    // Shaft state, always within the signed 32-bit range
    longint shaft_pos;
    longint shaft_vel;
    longint stiction_anchor;

    t_motion motion_due[$];
    int      mismatches;
    int      waiting;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic longint clip32(longint x);
        if (x > I32_MAX) return I32_MAX;
        if (x < I32_MIN) return I32_MIN;
        return x;
    endfunction

    function automatic longint gain_of(logic [30:0] g);
        return longint'({33'd0, g});
    endfunction

    // Advance the shaft by one Euler step and return the reported motion
    function automatic t_motion advance_plant(logic [31:0] dt_in,
                                              logic signed [31:0] cmd_in,
                                              logic signed [31:0] load_in);
        longint  dt_q, cmd, lim, band, diff, fric, damp, effort, acc, vel;
        longint  new_vel, new_pos;
        logic    on_stop;
        t_motion m;
        dt_q = longint'({32'd0, dt_in});
        cmd  = longint'(cmd_in);
        lim  = gain_of(plant_cfg.torque_limit);
        band = gain_of(plant_cfg.friction_torque) / STICTION_GAIN;
        if (cmd > lim) cmd = lim;
        if (cmd < -lim) cmd = -lim;

        // Drag the anchor so it stays within the stiction band
        diff = shaft_pos - stiction_anchor;
        if (diff < -band) stiction_anchor = clip32(shaft_pos + band);
        else if (diff > band) stiction_anchor = clip32(shaft_pos - band);
        fric = clip32((shaft_pos - stiction_anchor) * STICTION_GAIN);

        damp   = clip32((gain_of(plant_cfg.damping) * shaft_vel) >>> 16);
        effort = clip32(cmd + longint'(load_in) + fric - damp);
        acc    = clip32((effort * gain_of(plant_cfg.inertia_recip)) >>> 16);

        // Velocity first, then position with the new velocity
        vel     = shaft_vel + ((acc * dt_q) >>> 32);
        new_vel = clip32(vel);
        new_pos = clip32(shaft_pos + ((new_vel * dt_q) >>> 32));

        // Lower stop wins when the stops are crossed
        on_stop = 1'b0;
        if (new_pos < longint'(plant_cfg.position_min)) begin
            new_pos = longint'(plant_cfg.position_min);
            on_stop = 1'b1;
        end else if (new_pos > longint'(plant_cfg.position_max)) begin
            new_pos = longint'(plant_cfg.position_max);
            on_stop = 1'b1;
        end
        if (on_stop) begin
            new_vel = 0;
            effort  = 0;
        end

        shaft_pos = new_pos;
        shaft_vel = new_vel;

        m.position       = new_pos[31:0];
        m.velocity       = new_vel[31:0];
        m.effort_out     = effort[31:0];
        m.effort_valid   = !on_stop;
        m.applied_torque = cmd[31:0];
        return m;
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_motion want;
        if (!i_rst_n) begin
            plant_cfg.torque_limit    = TORQUE_LIMIT_RST;
            plant_cfg.friction_torque = '0;
            plant_cfg.damping         = '0;
            plant_cfg.inertia_recip   = INERTIA_RECIP_RST;
            plant_cfg.position_min    = POSITION_MIN_RST;
            plant_cfg.position_max    = POSITION_MAX_RST;
            shaft_pos       = 0;
            shaft_vel       = 0;
            stiction_anchor = 0;
            motion_due.delete();
        end else begin
            // Track register writes
            if (psel && penable && pwrite && pready) begin
                case (paddr[dcmp_pkg::APB_AW-1:2])
                    REG_TORQUE_LIMIT:    plant_cfg.torque_limit    = pwdata[30:0];
                    REG_FRICTION_TORQUE: plant_cfg.friction_torque = pwdata[30:0];
                    REG_DAMPING:         plant_cfg.damping         = pwdata[30:0];
                    REG_INERTIA_RECIP:   plant_cfg.inertia_recip   = pwdata[30:0];
                    REG_POSITION_MIN:    plant_cfg.position_min    = pwdata;
                    REG_POSITION_MAX:    plant_cfg.position_max    = pwdata;
                    default: ;
                endcase
            end

            // Compare each result with the oldest prediction
            if (result_ch.valid && result_ch.ready) begin
                if (motion_due.size() == 0) begin
                    $error("result item arrived with no input item waiting");
                    mismatches++;
                end else begin
                    want = motion_due.pop_front();
                    check_field("position", want.position, result_ch.position);
                    check_field("velocity", want.velocity, result_ch.velocity);
                    check_field("effort_out", want.effort_out, result_ch.effort_out);
                    check_field("effort_valid", longint'(want.effort_valid),
                                longint'(result_ch.effort_valid));
                    check_field("applied_torque", want.applied_torque,
                                result_ch.applied_torque);
                end
            end

            // Predict for each accepted input item
            if (item_ch.valid && item_ch.ready)
                motion_due.push_back(advance_plant(item_ch.dt, item_ch.motor_torque,
                                                   item_ch.load_torque));
        end
        waiting <= motion_due.size();
    end

endmodule

// ----- dv/tb_dc_motor_plant_step.sv -----
`timescale 1ns / 1ps

module tb_dc_motor_plant_step;
    import dcmp_pkg::*;
    import dcmp_reg_map_pkg::*;

    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 110;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    logic calm;
    int   stall_left;
    int   fail_count;
    int   pending;

    dcmp_in_if  item_ch ();
    dcmp_out_if result_ch ();

    dc_motor_plant_step dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dcmp_motion_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .item_ch      (item_ch),
        .result_ch    (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    // Stall the result side in random bursts, none once the run is calm
    always @(posedge i_clk) begin
        if (calm) begin
            result_ch.ready <= 1'b1;
            stall_left      <= 0;
        end else if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 8);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Setup cycle then access cycle; the bus stays selected for back-to-back writes
    task automatic apb_write(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_cfg(logic [30:0] lim, logic [30:0] fric, logic [30:0] damp,
                             logic [30:0] inv_j, logic signed [31:0] pmin,
                             logic signed [31:0] pmax);
        apb_write(REG_TORQUE_LIMIT, {1'b0, lim});
        apb_write(REG_FRICTION_TORQUE, {1'b0, fric});
        apb_write(REG_DAMPING, {1'b0, damp});
        apb_write(REG_INERTIA_RECIP, {1'b0, inv_j});
        apb_write(REG_POSITION_MIN, pmin);
        apb_write(REG_POSITION_MAX, pmax);
        apb_release();
    endtask

    // Drop valid and hold until every predicted result has come back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic send_item(logic [31:0] dt, logic signed [31:0] mt,
                             logic signed [31:0] lt);
        if (!calm && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.dt           <= dt;
        item_ch.motor_torque <= mt;
        item_ch.load_torque  <= lt;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
    endtask

    function automatic logic [30:0] pick_gain(int unsigned modest_max);
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 31'h7FFF_FFFF;
            4:       return 31'($urandom());
            default: return 31'($urandom_range(0, modest_max));
        endcase
    endfunction

    function automatic logic signed [31:0] pick_torque();
        if ($urandom_range(0, 3) == 0) return $signed($urandom());
        return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    endfunction

    task automatic write_random_cfg();
        logic signed [31:0] pmin;
        logic signed [31:0] pmax;
        case ($urandom_range(0, 5))
            0: begin
                pmin = 32'sh8000_0000;
                pmax = 32'sh7FFF_FFFF;
            end
            1: begin
                // Crossed stops
                pmin = $signed($urandom_range(0, 32'h0010_0000));
                pmax = -$signed($urandom_range(0, 32'h0010_0000));
            end
            default: begin
                pmin = -$signed($urandom_range(0, 32'h0100_0000));
                pmax = $signed($urandom_range(0, 32'h0100_0000));
            end
        endcase
        write_cfg(pick_gain(32'h0040_0000), pick_gain(32'h0400_0000),
                  pick_gain(32'h0004_0000), pick_gain(32'h0004_0000), pmin, pmax);
    endtask

    task automatic send_random_item();
        logic [31:0] dt;
        case ($urandom_range(0, 7))
            6:       dt = $urandom();
            7:       dt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: dt = $urandom_range(0, 32'h0400_0000);
        endcase
        send_item(dt, pick_torque(), pick_torque());
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        calm                 <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.dt           <= '0;
        item_ch.motor_torque <= '0;
        item_ch.load_torque  <= '0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: zero step, full-scale step, command at both rails
        send_item(32'h0, 32'sh0, 32'sh0);
        send_item(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh0);
        send_item(32'hFFFF_FFFF, 32'sh8000_0000, 32'sh8000_0000);
        send_item(32'h0000_0001, 32'sh0, 32'sh7FFF_FFFF);
        wait_drained();

        // Zero torque limit, full friction, damping and inertia gain, narrow stops
        write_cfg('0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  -32'sh0010_0000, 32'sh0010_0000);
        send_item(32'h8000_0000, 32'sh7FFF_FFFF, 32'sh0001_0000);
        send_item(32'h0100_0000, 32'sh0, 32'sh0200_0000);
        send_item(32'hFFFF_FFFF, 32'sh0, 32'sh8000_0000);
        send_item(32'h0010_0000, 32'sh0, 32'sh0000_8000);
        wait_drained();

        // Clamp the command both ways and walk the shaft through the stiction band
        write_cfg(31'h0003_0000, 31'(1000 * 32'h0001_0000), '0, INERTIA_RECIP_RST,
                  POSITION_MIN_RST, POSITION_MAX_RST);
        send_item(32'h1000_0000, 32'sh0005_0000, 32'sh0);
        send_item(32'h1000_0000, -32'sh0005_0000, 32'sh0);
        send_item(32'h1000_0000, 32'sh0003_0000, 32'sh0);
        send_item(32'h1000_0000, -32'sh0003_0000, -32'sh0001_0000);
        send_item(32'h1000_0000, 32'sh0, 32'sh0);
        wait_drained();

        // Crossed stops with zero inertia gain
        write_cfg(TORQUE_LIMIT_RST, '0, '0, '0, 32'sh0001_0000, -32'sh0001_0000);
        send_item(32'h4000_0000, 32'sh0001_0000, 32'sh0);
        send_item(32'h4000_0000, 32'sh0, 32'sh0);
        send_item(32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);

        // Random phases, each under fresh settings; the last runs without idling
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            calm <= (phase == PHASES - 1);
            write_random_cfg();
            repeat (PHASE_ITEMS) begin
                send_random_item();
                if (phase < PHASES - 1 && $urandom_range(0, 49) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (25) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS dc_motor_plant_step");
        else
            $display("FAIL dc_motor_plant_step");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAIL dc_motor_plant_step");
        $finish;
    end

endmodule
